### hdl/sla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sla_pkg
// Types and constants shared by the skyline atlas allocator modules.
// ----------------------------------------------------------------------------
package sla_pkg;

	localparam int MAX_ATLAS_SIZE = 1024;

	// Height of one skyline column and width of the request fields.
	localparam int HW = 11;
	// Width of the returned coordinates.
	localparam int XW = 10;

	localparam logic [HW-1:0] ATLAS_SIZE_RESET = 11'd1024;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	localparam logic ST_OK    = 1'b0;
	localparam logic ST_NOFIT = 1'b1;

	// Register index taken from paddr[2].
	localparam logic REG_ATLAS_SIZE = 1'b0;

	typedef enum logic [3:0] {
		EN_INIT,
		EN_IDLE,
		EN_CLEAR,
		EN_BACK,
		EN_TURN,
		EN_FWD,
		EN_DRAIN,
		EN_CHECK,
		EN_WRITE,
		EN_DONE
	} eng_state_t;

	typedef struct packed {
		logic          req_type;
		logic [HW-1:0] rect_width;
		logic [HW-1:0] rect_height;
	} req_t;

	typedef struct packed {
		logic          status;
		logic [XW-1:0] pos_x;
		logic [XW-1:0] pos_y;
	} res_t;

endpackage
`default_nettype wire

### hdl/sla_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sla_engine
// Skyline memory and the placement sequencer. Window maxima come from two
// passes with blocks of the rectangle width: a backward pass stores suffix
// maxima in a second memory, a forward pass forms prefix maxima and combines.
// ----------------------------------------------------------------------------
module sla_engine #(
	parameter int MAX_ATLAS_SIZE = sla_pkg::MAX_ATLAS_SIZE
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire sla_pkg::req_t                          req,
	input  wire logic [$clog2(MAX_ATLAS_SIZE+1)-1:0]    size,
	output logic                                        idle,
	output logic                                        res_valid,
	input  wire logic                                   res_ready,
	output sla_pkg::res_t                               res
);

	localparam int HW = sla_pkg::HW;
	localparam int XW = sla_pkg::XW;
	localparam int AW = $clog2(MAX_ATLAS_SIZE);
	localparam int CW = $clog2(MAX_ATLAS_SIZE + 1);
	localparam int EW = ((CW > HW) ? CW : HW) + 1;

	sla_pkg::eng_state_t state_q, state_d;

	logic [HW-1:0] w_q, h_q;
	logic [CW-1:0] size_q;
	logic [CW-1:0] ptr_q;
	logic [HW-1:0] cnt_q, c0_q, rem_q;
	logic [EW-1:0] best_q;
	logic [AW-1:0] bx_q;
	logic          found_q;
	logic [HW-1:0] run_q;
	sla_pkg::res_t res_q;

	logic          v_back_s1, v_fwd_s1, bnd_s1, win_s1;
	logic [AW-1:0] j_s1, i_s1;
	logic [HW-1:0] hrd_s1, srd_s1;

	logic [HW-1:0] hmem [MAX_ATLAS_SIZE];
	logic [HW-1:0] smem [MAX_ATLAS_SIZE];

	logic          h_we;
	logic [HW-1:0] h_wd;

	logic [HW-1:0] w_m1;
	logic [EW-1:0] ptr_e, w_e, sum_e;
	logic          last_back, last_fwd, last_sweep, win_issue, fits;
	logic [AW-1:0] i_issue;
	logic [HW-1:0] cnt_back_nx, cnt_fwd_nx;
	logic [HW-1:0] run_nx, win_max;
	logic          start_clear, bad_w;

	always_comb begin
		w_m1        = w_q - HW'(1);
		ptr_e       = EW'(ptr_q);
		w_e         = EW'(w_q);
		last_back   = (ptr_q == '0);
		last_fwd    = (ptr_q == size_q - CW'(2));
		last_sweep  = (ptr_q == CW'(MAX_ATLAS_SIZE - 1));
		win_issue   = (ptr_e >= w_e - EW'(1));
		i_issue     = AW'(ptr_e - EW'(w_m1));
		cnt_back_nx = (cnt_q == w_m1) ? '0 : cnt_q + HW'(1);
		cnt_fwd_nx  = (cnt_q == '0) ? w_m1 : cnt_q - HW'(1);
		sum_e       = best_q + EW'(h_q);
		fits        = found_q && (sum_e <= EW'(size_q));
		// Suffix maximum on the way down, prefix maximum on the way up.
		run_nx      = bnd_s1 ? hrd_s1 : ((hrd_s1 > run_q) ? hrd_s1 : run_q);
		win_max     = (run_nx > srd_s1) ? run_nx : srd_s1;
		start_clear = (req.req_type == sla_pkg::REQ_CLEAR);
		bad_w       = (req.rect_width == '0) || (EW'(req.rect_width) >= EW'(size));
		h_we        = (state_q == sla_pkg::EN_INIT) || (state_q == sla_pkg::EN_CLEAR) ||
		              (state_q == sla_pkg::EN_WRITE);
		h_wd        = (state_q == sla_pkg::EN_WRITE) ? HW'(sum_e) : '0;
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			hmem[ptr_q[AW-1:0]] <= h_wd;
		end
		hrd_s1 <= hmem[ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (v_back_s1) begin
			smem[j_s1] <= run_nx;
		end
		srd_s1 <= smem[i_issue];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sla_pkg::EN_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		idle      = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			sla_pkg::EN_INIT: begin
				if (last_sweep) state_d = sla_pkg::EN_IDLE;
			end
			sla_pkg::EN_IDLE: begin
				idle = 1'b1;
				if (start) begin
					if (start_clear) state_d = sla_pkg::EN_CLEAR;
					else if (bad_w) state_d = sla_pkg::EN_DONE;
					else state_d = sla_pkg::EN_BACK;
				end
			end
			sla_pkg::EN_CLEAR: begin
				if (last_sweep) state_d = sla_pkg::EN_DONE;
			end
			sla_pkg::EN_BACK: begin
				if (last_back) state_d = sla_pkg::EN_TURN;
			end
			sla_pkg::EN_TURN: begin
				state_d = sla_pkg::EN_FWD;
			end
			sla_pkg::EN_FWD: begin
				if (last_fwd) state_d = sla_pkg::EN_DRAIN;
			end
			sla_pkg::EN_DRAIN: begin
				state_d = sla_pkg::EN_CHECK;
			end
			sla_pkg::EN_CHECK: begin
				state_d = fits ? sla_pkg::EN_WRITE : sla_pkg::EN_DONE;
			end
			sla_pkg::EN_WRITE: begin
				if (rem_q == HW'(1)) state_d = sla_pkg::EN_DONE;
			end
			sla_pkg::EN_DONE: begin
				res_valid = 1'b1;
				if (res_ready) state_d = sla_pkg::EN_IDLE;
			end
			default: begin
				state_d = sla_pkg::EN_INIT;
			end
		endcase
	end

	// Control registers of the sequencer and the read pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			found_q   <= 1'b0;
			v_back_s1 <= 1'b0;
			v_fwd_s1  <= 1'b0;
		end else begin
			v_back_s1 <= (state_q == sla_pkg::EN_BACK);
			v_fwd_s1  <= (state_q == sla_pkg::EN_FWD);
			case (state_q)
				sla_pkg::EN_INIT, sla_pkg::EN_CLEAR, sla_pkg::EN_FWD,
				sla_pkg::EN_WRITE: begin
					ptr_q <= ptr_q + CW'(1);
				end
				sla_pkg::EN_IDLE: begin
					if (start) begin
						ptr_q   <= start_clear ? '0 : size - CW'(1);
						found_q <= 1'b0;
					end
				end
				sla_pkg::EN_BACK: begin
					ptr_q <= ptr_q - CW'(1);
				end
				sla_pkg::EN_TURN: begin
					ptr_q <= '0;
				end
				sla_pkg::EN_CHECK: begin
					ptr_q <= CW'(bx_q);
				end
				default: begin
				end
			endcase
			if (v_fwd_s1 && win_s1 && (EW'(win_max) < best_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= ptr_q[AW-1:0];
		i_s1 <= i_issue;
		if (state_q == sla_pkg::EN_BACK) begin
			bnd_s1 <= (cnt_q == '0);
			win_s1 <= 1'b0;
		end else begin
			bnd_s1 <= (ptr_q == '0) || (cnt_q == w_m1);
			win_s1 <= win_issue;
		end
		if (v_back_s1 || v_fwd_s1) begin
			run_q <= run_nx;
		end
		// A later start wins only when its window is strictly lower.
		if (v_fwd_s1 && win_s1 && (EW'(win_max) < best_q)) begin
			best_q <= EW'(win_max);
			bx_q   <= i_s1;
		end
		case (state_q)
			sla_pkg::EN_IDLE: begin
				if (start) begin
					w_q    <= req.rect_width;
					h_q    <= req.rect_height;
					size_q <= size;
					best_q <= EW'(size);
					cnt_q  <= '0;
					res_q  <= '{status: sla_pkg::ST_NOFIT, pos_x: '0, pos_y: '0};
				end
			end
			sla_pkg::EN_CLEAR: begin
				res_q <= '{status: sla_pkg::ST_OK, pos_x: '0, pos_y: '0};
			end
			sla_pkg::EN_BACK: begin
				cnt_q <= cnt_back_nx;
				if (last_back) c0_q <= cnt_q;
			end
			sla_pkg::EN_TURN: begin
				cnt_q <= c0_q;
			end
			sla_pkg::EN_FWD: begin
				cnt_q <= cnt_fwd_nx;
			end
			sla_pkg::EN_CHECK: begin
				rem_q <= w_q;
				if (fits) begin
					res_q <= '{status: sla_pkg::ST_OK, pos_x: XW'(bx_q), pos_y: XW'(best_q)};
				end else begin
					res_q <= '{status: sla_pkg::ST_NOFIT, pos_x: '0, pos_y: '0};
				end
			end
			sla_pkg::EN_WRITE: begin
				rem_q <= rem_q - HW'(1);
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule
`default_nettype wire

### hdl/skyline_atlas_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skyline_atlas_allocator_top
// Places rectangles in a square atlas from a skyline of column heights kept in
// a single-port memory. Requests are taken one at a time; a new one is taken
// while the previous result still waits on the output register. An allocation
// makes one backward pass over the columns to store block suffix maxima, one
// forward pass to find the lowest window and, when the rectangle fits, one
// write per raised column, each limited by one memory access per cycle. The
// atlas side used is capped at MAX_ATLAS_SIZE. A request with a zero width or
// one not below the atlas side is answered without any pass over the columns.
// A clear, and the clearing pass after reset, sweep all MAX_ATLAS_SIZE columns
// at one per cycle; no request is taken during either sweep. The atlas size
// register sits at APB address 0 and should be written only while the block
// is idle.
// ----------------------------------------------------------------------------
module skyline_atlas_allocator_top #(
	parameter int MAX_ATLAS_SIZE = sla_pkg::MAX_ATLAS_SIZE
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // rect_width, rect_height
	input  wire logic [0:0]  s_axis_tuser,  // req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [23:0] m_axis_tdata,  // pos_x, pos_y
	output logic      [0:0]  m_axis_tuser   // status
);

	localparam int HW = sla_pkg::HW;
	localparam int CW = $clog2(MAX_ATLAS_SIZE + 1);
	localparam int SW = (CW > HW) ? CW : HW;

	logic [HW-1:0] atlas_q;
	logic [SW-1:0] atlas_e;
	logic [CW-1:0] size_eff;

	sla_pkg::req_t req;
	sla_pkg::res_t eng_res, m_res_q;
	logic          eng_idle, eng_valid, eng_ready, m_valid_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_q <= sla_pkg::ATLAS_SIZE_RESET;
		end else if (psel && penable && pwrite && pready &&
		             (paddr[2] == sla_pkg::REG_ATLAS_SIZE)) begin
			atlas_q <= pwdata[HW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == sla_pkg::REG_ATLAS_SIZE) begin
			prdata = 32'(atlas_q);
		end
	end

	// Sizes above the memory depth are used as the full depth.
	always_comb begin
		atlas_e  = SW'(atlas_q);
		size_eff = (atlas_e > SW'(MAX_ATLAS_SIZE)) ? CW'(MAX_ATLAS_SIZE) : CW'(atlas_e);
	end

	assign req = '{req_type:    s_axis_tuser[0],
	               rect_width:  s_axis_tdata[10:0],
	               rect_height: s_axis_tdata[21:11]};

	assign s_axis_tready = eng_idle;

	sla_engine #(
		.MAX_ATLAS_SIZE(MAX_ATLAS_SIZE)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_axis_tvalid && s_axis_tready),
		.req       (req),
		.size      (size_eff),
		.idle      (eng_idle),
		.res_valid (eng_valid),
		.res_ready (eng_ready),
		.res       (eng_res)
	);

	// Output register: the engine hands over its result when the slot is free.
	assign eng_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (eng_ready) begin
			m_valid_q <= eng_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_valid && eng_ready) begin
			m_res_q <= eng_res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0, m_res_q.pos_y, m_res_q.pos_x};
	assign m_axis_tuser  = m_res_q.status;

endmodule
`default_nettype wire
